// File: src/psc_pkg.sv
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types and constants for the postfix stack calculator.
// ----------------------------------------------------------------------------
package psc_pkg;

  localparam int Q_W        = 32;  // Q16.16 word
  localparam int FRAC_W     = 16;
  localparam int OP_W       = 3;
  localparam int DEPTH_W    = 5;   // reported depth field
  localparam int STATUS_W   = 3;
  localparam int PROD_W     = 2 * Q_W;
  localparam int DIVIDEND_W = Q_W + FRAC_W;
  localparam int DIV_CW     = $clog2(DIVIDEND_W);

  localparam logic [OP_W-1:0] OP_PUSH  = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD   = 3'd1;
  localparam logic [OP_W-1:0] OP_SUB   = 3'd2;
  localparam logic [OP_W-1:0] OP_MUL   = 3'd3;
  localparam logic [OP_W-1:0] OP_DIV   = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR = 3'd5;

  localparam logic signed [PROD_W-1:0] Q_MAX = PROD_W'(64'sd2147483647);
  localparam logic signed [PROD_W-1:0] Q_MIN = -PROD_W'(64'sd2147483648);

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_OVERFLOW  = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_DIVZERO   = 3'd3,
    ST_INVALID   = 3'd4,
    ST_SATURATED = 3'd5
  } psc_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_LOAD,
    S_DIV,
    S_COMMIT,
    S_REPLY
  } psc_state_t;

  typedef struct packed {
    logic [OP_W-1:0]        operation;
    logic signed [Q_W-1:0]  operand_value;
  } psc_in_t;

  typedef struct packed {
    logic signed [Q_W-1:0]  top_value;
    logic [DEPTH_W-1:0]     stack_depth;
    logic [STATUS_W-1:0]    status;
  } psc_out_t;

  // controller -> datapath
  typedef struct packed {
    logic        load_in;     // capture the input transfer
    logic        push;        // write operand at pointer, pointer up
    logic        clear;
    logic        rd_below;    // read entry under the top
    logic        capture;     // form sum/product or start divider
    logic        commit;      // clamp, write back, pointer down
    logic        set_status;
    psc_status_t status_code;
    logic        out_load;    // load output register
  } psc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            has_two;
    logic            top_zero;
    logic            div_busy;
    logic            out_free;
  } psc_stat_t;

endpackage

// File: src/psc_stream_if.sv
// ----------------------------------------------------------------------------
// psc_stream_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface psc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: src/postfix_stack_calculator.sv
// Sequence: push, clear and failed operations go from the transfer through decode
// to reply; add, subtract and multiply add a load and a commit step; divide also
// waits in the 48-step restoring divider (one quotient bit a cycle).
// Throughput: one item in flight; the next transfer is taken as soon as the
// result sits in the output register, even while that result still waits.
// Reset (rst, synchronous): stack emptied, sequencer idle, no result pending.
// ----------------------------------------------------------------------------
// postfix_stack_calculator
// Postfix calculator over a bounded stack of signed Q16.16 operands.
// ----------------------------------------------------------------------------
module postfix_stack_calculator #(
  parameter int STACK_DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  psc_stream_if.sink    in_ch,
  psc_stream_if.source  out_ch
);
  import psc_pkg::*;

  // Control/status between sequencer and datapath
  psc_cmd_t  cmd;
  psc_stat_t stat;
  psc_in_t   in_data;
  psc_out_t  out_data;

  // Input payload is captured by the datapath on the transfer cycle; the
  // sequencer only owns the handshake.
  assign in_data.operation     = in_ch.payload.operation;
  assign in_data.operand_value = in_ch.payload.operand_value;

  psc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath holds the stack RAM, the cached top entry (so arithmetic needs
  // a single RAM read for the entry below), the ALU with saturation, the
  // divider and the output register.
  psc_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  // Result fields straight from the output register
  assign out_ch.payload.top_value   = out_data.top_value;
  assign out_ch.payload.stack_depth = out_data.stack_depth;
  assign out_ch.payload.status      = out_data.status;
endmodule

// File: src/psc_ram.sv
// ----------------------------------------------------------------------------
// psc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module psc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// File: src/psc_div.sv
// ----------------------------------------------------------------------------
// psc_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psc_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [psc_pkg::DIVIDEND_W-1:0] dividend,
  input  logic [psc_pkg::Q_W-1:0]        divisor,
  output logic                           busy,
  output logic [psc_pkg::DIVIDEND_W-1:0] quotient
);
  import psc_pkg::*;

  logic [DIV_CW-1:0]     cnt;
  logic [Q_W-1:0]        rem;
  logic [Q_W-1:0]        dvs;
  logic [DIVIDEND_W-1:0] dq;     // dividend shifts out, quotient shifts in
  logic [Q_W:0]          shifted;
  logic [Q_W+1:0]        diff;
  logic                  ge;

  assign shifted  = {rem, dq[DIVIDEND_W-1]};
  assign diff     = {1'b0, shifted} - {2'b00, dvs};
  assign ge       = ~diff[Q_W+1];
  assign quotient = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == '0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= DIV_CW'(DIVIDEND_W - 1);
      rem <= '0;
      dvs <= divisor;
      dq  <= dividend;
    end else if (busy) begin
      cnt <= cnt - DIV_CW'(1);
      rem <= ge ? diff[Q_W-1:0] : shifted[Q_W-1:0];
      dq  <= {dq[DIVIDEND_W-2:0], ge};
    end
  end
endmodule

// File: src/psc_dp.sv
// ----------------------------------------------------------------------------
// psc_dp
// Datapath: stack RAM, pointer, cached top, ALU, divider, output register.
// ----------------------------------------------------------------------------
module psc_dp #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  psc_pkg::psc_cmd_t   cmd,
  output psc_pkg::psc_stat_t  stat,
  input  psc_pkg::psc_in_t    in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output psc_pkg::psc_out_t   out_data
);
  import psc_pkg::*;

  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);

  logic [OP_W-1:0]          op;
  logic signed [Q_W-1:0]    operand;
  logic [SPW-1:0]           sp;
  logic signed [Q_W-1:0]    top;
  logic signed [PROD_W-1:0] res;
  logic [STATUS_W-1:0]      status;

  logic [AW-1:0]            below_addr;
  logic [Q_W-1:0]           rdata;
  logic signed [Q_W-1:0]    below;
  logic signed [PROD_W-1:0] below_x, top_x, product;
  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [Q_W-1:0]           ram_wdata;

  logic [Q_W-1:0]           below_mag, top_mag;
  logic                     div_neg;
  logic [DIVIDEND_W-1:0]    quot;
  logic signed [PROD_W-1:0] quot_s;
  logic signed [PROD_W-1:0] value;
  logic signed [Q_W-1:0]    clamped;
  logic                     sat;

  assign below_addr = AW'(sp - SPW'(2));
  assign below      = signed'(rdata);
  assign below_x    = {{Q_W{below[Q_W-1]}}, below};
  assign top_x      = {{Q_W{top[Q_W-1]}}, top};
  assign product    = below * top;

  assign below_mag  = below[Q_W-1] ? Q_W'(-below) : Q_W'(below);
  assign top_mag    = top[Q_W-1] ? Q_W'(-top) : Q_W'(top);

  psc_ram #(
    .WIDTH (Q_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_below),
    .raddr (below_addr),
    .rdata (rdata)
  );

  psc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.capture && op == OP_DIV),
    .dividend ({below_mag, {FRAC_W{1'b0}}}),
    .divisor  (top_mag),
    .busy     (stat.div_busy),
    .quotient (quot)
  );

  // quotient truncates toward zero: sign applied to the magnitude
  assign quot_s = div_neg ? -PROD_W'(quot) : PROD_W'(quot);

  always_comb begin
    case (op)
      OP_MUL:  value = res >>> FRAC_W;   // floor
      OP_DIV:  value = quot_s;
      default: value = res;
    endcase
    sat = 1'b0;
    if (value > Q_MAX) begin
      clamped = Q_MAX[Q_W-1:0];
      sat     = 1'b1;
    end else if (value < Q_MIN) begin
      clamped = Q_MIN[Q_W-1:0];
      sat     = 1'b1;
    end else begin
      clamped = value[Q_W-1:0];
    end
  end

  assign ram_we    = cmd.push | cmd.commit;
  assign ram_waddr = cmd.push ? sp[AW-1:0] : below_addr;
  assign ram_wdata = cmd.push ? operand : clamped;

  assign stat.op       = op;
  assign stat.full     = (sp == SPW'(STACK_DEPTH));
  assign stat.has_two  = (sp >= SPW'(2));
  assign stat.top_zero = (top == '0);
  assign stat.out_free = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
    end else if (cmd.clear) begin
      sp <= '0;
    end else if (cmd.push) begin
      sp <= sp + SPW'(1);
    end else if (cmd.commit) begin
      sp <= sp - SPW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op      <= in_data.operation;
      operand <= in_data.operand_value;
    end
    if (cmd.push) begin
      top <= operand;
    end else if (cmd.commit) begin
      top <= clamped;
    end
    if (cmd.capture) begin
      case (op)
        OP_ADD:  res <= below_x + top_x;
        OP_SUB:  res <= below_x - top_x;
        default: res <= product;
      endcase
      div_neg <= below[Q_W-1] ^ top[Q_W-1];
    end
    if (cmd.set_status) begin
      status <= cmd.status_code;
    end else if (cmd.commit) begin
      status <= sat ? ST_SATURATED : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.top_value   <= (sp != '0) ? top : '0;
      out_data.stack_depth <= DEPTH_W'(sp);
      out_data.status      <= status;
    end
  end
endmodule

// File: src/psc_ctrl.sv
// ----------------------------------------------------------------------------
// psc_ctrl
// Sequencer: decodes each operation and steps the datapath through it.
// ----------------------------------------------------------------------------
module psc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  psc_pkg::psc_stat_t  stat,
  output psc_pkg::psc_cmd_t   cmd
);
  import psc_pkg::*;

  psc_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        case (stat.op)
          OP_ADD, OP_SUB, OP_MUL: begin
            state_next = stat.has_two ? S_LOAD : S_REPLY;
          end
          OP_DIV: begin
            state_next = (stat.has_two && !stat.top_zero) ? S_LOAD : S_REPLY;
          end
          default: state_next = S_REPLY;
        endcase
      end
      S_LOAD: begin
        state_next = (stat.op == OP_DIV) ? S_DIV : S_COMMIT;
      end
      S_DIV: begin
        if (!stat.div_busy) state_next = S_COMMIT;
      end
      S_COMMIT: state_next = S_REPLY;
      S_REPLY: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      S_DECODE: begin
        case (stat.op)
          OP_PUSH: begin
            cmd.set_status  = 1'b1;
            cmd.status_code = stat.full ? ST_OVERFLOW : ST_OK;
            cmd.push        = ~stat.full;
          end
          OP_CLEAR: begin
            cmd.clear       = 1'b1;
            cmd.set_status  = 1'b1;
            cmd.status_code = ST_OK;
          end
          OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
            if (!stat.has_two) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_UNDERFLOW;
            end else if (stat.op == OP_DIV && stat.top_zero) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_DIVZERO;
            end else begin
              cmd.rd_below = 1'b1;
            end
          end
          default: begin
            cmd.set_status  = 1'b1;
            cmd.status_code = ST_INVALID;
          end
        endcase
      end
      S_LOAD:   cmd.capture  = 1'b1;
      S_COMMIT: cmd.commit   = 1'b1;
      S_REPLY:  cmd.out_load = stat.out_free;
      default: ;
    endcase
  end
endmodule

// File: tb/postfix_stack_calculator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// postfix_stack_calculator_tb
// Self-checking bench for the postfix stack calculator. Operation items go in
// on a valid/ready channel and each result is checked field by field against
// a local Q16.16 stack model: directed corner cases first, then random
// expression, fill, run-dry, noise and clear sequences, with random gaps on both sides.
// ----------------------------------------------------------------------------
module postfix_stack_calculator_tb;
  import psc_pkg::*;

  localparam int CALC_DEPTH  = 16;
  localparam int STALL_LIMIT = 2000;  // cycles with no transfer on either side
  localparam int DRAIN_WAIT  = 80;    // extra wait after the last result, as margin
  localparam int ITEM_TARGET = 1400;
  localparam int GAP_PCT     = 30;
  // no gaps at all on either side while this many transfers are in
  localparam int QUIET_FROM  = 500;
  localparam int QUIET_TO    = 800;

  // operation codes that the block must reject
  localparam logic [OP_W-1:0] OP_BAD_A = 3'd6;
  localparam logic [OP_W-1:0] OP_BAD_B = 3'd7;

  localparam logic signed [Q_W-1:0] Q16_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [Q_W-1:0] Q16_MIN = 32'sh8000_0000;
  localparam logic signed [Q_W-1:0] Q16_ONE = 32'sh0001_0000;

  logic clk = 1'b0;
  logic rst;

  psc_stream_if #(.payload_t(psc_in_t))  in_ch ();
  psc_stream_if #(.payload_t(psc_out_t)) out_ch ();

  postfix_stack_calculator #(
    .STACK_DEPTH(CALC_DEPTH)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  psc_in_t  pending_items[$];     // operations not yet transferred
  psc_out_t expected_results[$];  // predicted results, oldest first

  // Local copy of the operand stack, advanced once per accepted operation.
  logic signed [Q_W-1:0] calc_stack [CALC_DEPTH];
  int calc_depth = 0;

  int items_accepted = 0;
  int error_count    = 0;
  int stall_cycles   = 0;
  int gen_depth      = 0;  // rough depth seen by the generator

  task automatic flag_error(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    error_count++;
  endtask

  // Gaps are off inside the quiet window, otherwise roughly GAP_PCT percent.
  function automatic bit take_gap();
    if (items_accepted >= QUIET_FROM && items_accepted < QUIET_TO) return 1'b0;
    return $urandom_range(99) < GAP_PCT;
  endfunction

  // Apply one operation to the local stack and return the expected result.
  function automatic psc_out_t evaluate_item(input psc_in_t item);
    longint      top_v;
    longint      below_v;
    longint      res;
    bit          writes_back;
    psc_status_t st;
    psc_out_t    result;
    st          = ST_OK;
    res         = 0;
    writes_back = 1'b0;
    case (item.operation)
      OP_PUSH: begin
        if (calc_depth >= CALC_DEPTH) begin
          st = ST_OVERFLOW;
        end else begin
          calc_stack[calc_depth] = item.operand_value;
          calc_depth++;
        end
      end
      OP_CLEAR: begin
        calc_depth = 0;
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
        if (calc_depth < 2) begin
          st = ST_UNDERFLOW;
        end else begin
          top_v       = calc_stack[calc_depth-1];
          below_v     = calc_stack[calc_depth-2];
          writes_back = 1'b1;
          case (item.operation)
            OP_ADD: res = below_v + top_v;
            OP_SUB: res = below_v - top_v;
            // product is exact in 64 bits; the shift floors
            OP_MUL: res = (below_v * top_v) >>> FRAC_W;
            default: begin
              if (top_v == 0) begin
                st          = ST_DIVZERO;
                writes_back = 1'b0;
              end else begin
                // signed division truncates toward zero
                res = (below_v * 65536) / top_v;
              end
            end
          endcase
          if (writes_back) begin
            if (res > Q_MAX) begin
              res = Q_MAX;
              st  = ST_SATURATED;
            end else if (res < Q_MIN) begin
              res = Q_MIN;
              st  = ST_SATURATED;
            end
            calc_depth--;
            calc_stack[calc_depth-1] = res[Q_W-1:0];
          end
        end
      end
      default: st = ST_INVALID;
    endcase
    result.top_value   = (calc_depth > 0) ? calc_stack[calc_depth-1] : '0;
    result.stack_depth = calc_depth[DEPTH_W-1:0];
    result.status      = st;
    return result;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_item(input logic [OP_W-1:0] op, input logic signed [Q_W-1:0] value);
    psc_in_t item;
    item.operation     = op;
    item.operand_value = value;
    pending_items.push_back(item);
    // divide by zero is not tracked here, so the depth may drift from the real one
    case (op)
      OP_PUSH:  if (gen_depth < CALC_DEPTH) gen_depth++;
      OP_CLEAR: gen_depth = 0;
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: if (gen_depth >= 2) gen_depth--;
      default: ;
    endcase
  endtask

  function automatic logic [OP_W-1:0] random_arith_op();
    case ($urandom_range(3))
      0: return OP_ADD;
      1: return OP_SUB;
      2: return OP_MUL;
      default: return OP_DIV;
    endcase
  endfunction

  // Mostly small values so that results stay in range, with a share of full
  // words, extremes, whole numbers and pure fractions.
  function automatic logic signed [Q_W-1:0] random_operand();
    int pick;
    pick = $urandom_range(9);
    if (pick <= 3) return int'($urandom_range(1 << 20)) - (1 << 19);
    if (pick <= 6) return $urandom;
    if (pick == 7) begin
      case ($urandom_range(5))
        0: return Q16_MAX;
        1: return Q16_MIN;
        2: return '0;
        3: return Q16_ONE;
        4: return -Q16_ONE;
        default: return 32'sd1;
      endcase
    end
    if (pick == 8) return (int'($urandom_range(64)) - 32) <<< FRAC_W;
    return int'($urandom_range(65535)) - (($urandom_range(1) != 0) ? 65536 : 0);
  endfunction

  // Push up to a full stack, push a few more against it, then fold back down.
  task automatic queue_fill_sequence();
    int extra;
    int j;
    while (gen_depth < CALC_DEPTH) queue_item(OP_PUSH, random_operand());
    extra = $urandom_range(1, 3);
    for (j = 0; j < extra; j++) queue_item(OP_PUSH, random_operand());
    extra = $urandom_range(2, 8);
    for (j = 0; j < extra; j++) queue_item(random_arith_op(), random_operand());
  endtask

  // --------------------------------------------------------------------------
  // Driver: presents pending operations; holds payload until the transfer.
  // The prediction is taken at the edge where the transfer happens.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(evaluate_item(in_ch.payload));
        items_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_items.size() != 0 && !take_gap()) begin
          in_ch.valid   <= 1'b1;
          in_ch.payload <= pending_items.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: random back-pressure; each result transfer is checked against
  // the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    psc_out_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          flag_error($sformatf("result with nothing expected: top %h depth %0d status %0d",
                               out_ch.payload.top_value, out_ch.payload.stack_depth,
                               out_ch.payload.status));
        end else begin
          want = expected_results.pop_front();
          if (out_ch.payload.top_value !== want.top_value)
            flag_error($sformatf("top_value got %h want %h",
                                 out_ch.payload.top_value, want.top_value));
          if (out_ch.payload.stack_depth !== want.stack_depth)
            flag_error($sformatf("stack_depth got %0d want %0d",
                                 out_ch.payload.stack_depth, want.stack_depth));
          if (out_ch.payload.status !== want.status)
            flag_error($sformatf("status got %0d want %0d",
                                 out_ch.payload.status, want.status));
        end
      end
      out_ch.ready <= !take_gap();
    end
  end

  // Watchdog: too long with no transfer on either channel means a hang.
  always @(posedge clk) begin
    if (rst) begin
      stall_cycles = 0;
    end else begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("** postfix_stack_calculator: FAILED **");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int kind;
    int n;
    int k;
    int j;
    rst = 1'b1;

    // Directed part: error codes on an empty stack, then saturation in each
    // direction, divide by zero, and the rounding of multiply and divide.
    queue_item(OP_ADD, '0);          // underflow on empty stack
    queue_item(OP_BAD_A, Q16_MAX);   // invalid codes
    queue_item(OP_BAD_B, '0);
    queue_item(OP_CLEAR, '0);        // clear when already empty
    queue_item(OP_PUSH, Q16_MIN);
    queue_item(OP_SUB, '0);          // underflow with one entry
    queue_item(OP_PUSH, -Q16_ONE);
    queue_item(OP_DIV, '0);          // min / -1.0 saturates high
    queue_item(OP_PUSH, Q16_MAX);
    queue_item(OP_MUL, '0);          // max * max saturates high
    queue_item(OP_PUSH, '0);
    queue_item(OP_DIV, '0);          // divide by zero, stack kept
    queue_item(OP_PUSH, Q16_MIN);
    queue_item(OP_ADD, '0);          // 0 + min
    queue_item(OP_PUSH, Q16_MAX);
    queue_item(OP_SUB, '0);          // min - max saturates low
    queue_item(OP_MUL, '0);          // max * min saturates low
    queue_item(OP_PUSH, 32'shFFFF_FFFF);
    queue_item(OP_PUSH, 32'sh0000_8000);
    queue_item(OP_MUL, '0);          // -ulp * 0.5 floors to -ulp
    queue_item(OP_PUSH, 32'shFFFF_FFFF);
    queue_item(OP_PUSH, 3 * Q16_ONE);
    queue_item(OP_DIV, '0);          // -ulp / 3.0 truncates to zero
    queue_item(OP_CLEAR, '0);
    gen_depth = 0;

    // Random part, opening with a run into a full stack.
    queue_fill_sequence();
    while (pending_items.size() < ITEM_TARGET) begin
      kind = $urandom_range(99);
      if (kind < 55) begin
        // well-formed expression: n operands then n-1 operators, sometimes one
        // operator too many
        n = $urandom_range(2, 5);
        for (j = 0; j < n; j++) queue_item(OP_PUSH, random_operand());
        k = $urandom_range(n - 1, n);
        for (j = 0; j < k; j++) queue_item(random_arith_op(), '0);
      end else if (kind < 65) begin
        queue_fill_sequence();
      end else if (kind < 80) begin
        // operators until the stack runs dry
        k = gen_depth + 1;
        for (j = 0; j < k; j++) queue_item(random_arith_op(), random_operand());
      end else if (kind < 95) begin
        // noise: any code, any value
        n = $urandom_range(1, 4);
        for (j = 0; j < n; j++) queue_item(OP_W'($urandom_range(7)), $urandom);
      end else begin
        queue_item(OP_CLEAR, random_operand());
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (pending_items.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (error_count == 0) begin
      $display("** postfix_stack_calculator: PASSED **");
    end else begin
      $display("** postfix_stack_calculator: FAILED **");
    end
    $finish;
  end

endmodule
